[sv/itp_pkg.sv]
`timescale 1ns / 1ps

package itp_pkg;

    // Character codes the parser looks for
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    // Positions inside the string
    localparam logic [4:0] POS_DATE_ONLY = 5'd10;
    localparam logic [4:0] POS_SEP_TIME  = 5'd10;
    localparam logic [4:0] POS_NO_FRAC   = 5'd19;
    localparam logic [4:0] POS_DOT       = 5'd19;
    localparam logic [4:0] POS_MIN_FRAC  = 5'd21;
    localparam logic [4:0] POS_MAX       = 5'd31;

    // Default depth of the queue between parser and date unit
    localparam int QUEUE_DEPTH = 2;

    // Date arithmetic constants
    localparam logic [12:0] DIV400_RECIP = 13'd5243;   // 2^21 / 400, rounded up
    localparam int          DIV400_SHIFT = 21;
    localparam logic signed [22:0] DAYS_PER_ERA = 23'sd146097;
    localparam logic signed [22:0] EPOCH_SHIFT  = 23'sd719468;

    // One parsed string, handed from the parser to the date unit
    typedef struct packed {
        logic        ok;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  sec;
        logic [9:0]  millis;
    } t_rec;

    // Day of the year at which a month starts, years counted from March
    function automatic logic [8:0] month_offset(input logic [3:0] month);
        logic [8:0] off;
        unique case (month)
            4'd3:    off = 9'd0;
            4'd4:    off = 9'd31;
            4'd5:    off = 9'd61;
            4'd6:    off = 9'd92;
            4'd7:    off = 9'd122;
            4'd8:    off = 9'd153;
            4'd9:    off = 9'd184;
            4'd10:   off = 9'd214;
            4'd11:   off = 9'd245;
            4'd12:   off = 9'd275;
            4'd1:    off = 9'd306;
            4'd2:    off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

[sv/itp_front.sv]
`timescale 1ns / 1ps

module itp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_char_code,
    input  logic              i_last_char,
    input  logic              i_full,
    output logic              o_push,
    output itp_pkg::t_rec     o_rec
);

    logic [4:0]  r_pos,   n_pos;
    logic [13:0] r_year,  n_year;
    logic [6:0]  r_month, n_month;
    logic [6:0]  r_day,   n_day;
    logic [6:0]  r_hour,  n_hour;
    logic [6:0]  r_min,   n_min;
    logic [6:0]  r_sec,   n_sec;
    logic [9:0]  r_ms,    n_ms;
    logic [1:0]  r_fds,   n_fds;
    logic        r_frac,  n_frac;
    logic        r_err,   n_err;

    logic        w_acc;
    logic        w_isdig;
    logic [3:0]  w_dig;
    logic [9:0]  w_scale;
    logic        w_len_ok;
    logic        w_ok;

    assign o_ready = !i_full;
    assign w_acc   = i_valid && o_ready;
    assign w_isdig = (i_char_code >= itp_pkg::CH_ZERO) && (i_char_code <= itp_pkg::CH_NINE);
    assign w_dig   = w_isdig ? i_char_code[3:0] : 4'd0;

    // Classify the character by its position and fold it into the fields
    always_comb begin
        n_pos   = r_pos;
        n_year  = r_year;
        n_month = r_month;
        n_day   = r_day;
        n_hour  = r_hour;
        n_min   = r_min;
        n_sec   = r_sec;
        n_ms    = r_ms;
        n_fds   = r_fds;
        n_frac  = r_frac;
        n_err   = r_err;
        w_scale = (r_fds == 2'd0) ? 10'd100 : ((r_fds == 2'd1) ? 10'd10 : 10'd1);

        priority if (r_pos <= 5'd3) begin
            if (w_isdig) n_year = 14'(r_year * 14'd10 + 14'(w_dig));
            else n_err = 1'b1;
        end else if (r_pos == 5'd4 || r_pos == 5'd7) begin
            if (i_char_code != itp_pkg::CH_DASH) n_err = 1'b1;
        end else if (r_pos == 5'd5 || r_pos == 5'd6) begin
            if (w_isdig) n_month = 7'(r_month * 7'd10 + 7'(w_dig));
            else n_err = 1'b1;
        end else if (r_pos == 5'd8 || r_pos == 5'd9) begin
            if (w_isdig) n_day = 7'(r_day * 7'd10 + 7'(w_dig));
            else n_err = 1'b1;
        end else if (r_pos == itp_pkg::POS_SEP_TIME) begin
            if (i_char_code != itp_pkg::CH_T && i_char_code != itp_pkg::CH_SPACE) n_err = 1'b1;
        end else if (r_pos == 5'd11 || r_pos == 5'd12) begin
            if (w_isdig) n_hour = 7'(r_hour * 7'd10 + 7'(w_dig));
            else n_err = 1'b1;
        end else if (r_pos == 5'd13 || r_pos == 5'd16) begin
            if (i_char_code != itp_pkg::CH_COLON) n_err = 1'b1;
        end else if (r_pos == 5'd14 || r_pos == 5'd15) begin
            if (w_isdig) n_min = 7'(r_min * 7'd10 + 7'(w_dig));
            else n_err = 1'b1;
        end else if (r_pos == 5'd17 || r_pos == 5'd18) begin
            if (w_isdig) n_sec = 7'(r_sec * 7'd10 + 7'(w_dig));
            else n_err = 1'b1;
        end else if (r_pos == itp_pkg::POS_DOT) begin
            if (i_char_code == itp_pkg::CH_DOT) n_frac = 1'b1;
            else n_err = 1'b1;
        end else begin
            if (!r_frac || !w_isdig) begin
                n_err = 1'b1;
            end else if (r_fds != 2'd3) begin
                n_ms  = 10'(r_ms + 10'(w_dig) * w_scale);
                n_fds = 2'(r_fds + 2'd1);
            end
        end

        if (r_pos != itp_pkg::POS_MAX) n_pos = 5'(r_pos + 5'd1);
    end

    // Judge the finished string
    assign w_len_ok = (n_pos == itp_pkg::POS_DATE_ONLY) || (n_pos == itp_pkg::POS_NO_FRAC) ||
                      (n_frac && n_pos >= itp_pkg::POS_MIN_FRAC);
    assign w_ok = !n_err && w_len_ok &&
                  (n_month >= 7'd1) && (n_month <= 7'd12) &&
                  (n_day >= 7'd1) && (n_day <= 7'd31) &&
                  (n_hour <= 7'd23) && (n_min <= 7'd59) && (n_sec <= 7'd59);

    assign o_push       = w_acc && i_last_char;
    assign o_rec.ok     = w_ok;
    assign o_rec.year   = n_year;
    assign o_rec.month  = n_month[3:0];
    assign o_rec.day    = n_day[4:0];
    assign o_rec.hour   = n_hour[4:0];
    assign o_rec.minute = n_min[5:0];
    assign o_rec.sec    = n_sec[5:0];
    assign o_rec.millis = n_ms;

    // Advance parser state; clear it on reset and after the last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_acc && i_last_char)) begin
            r_pos   <= '0;
            r_year  <= '0;
            r_month <= '0;
            r_day   <= '0;
            r_hour  <= '0;
            r_min   <= '0;
            r_sec   <= '0;
            r_ms    <= '0;
            r_fds   <= '0;
            r_frac  <= 1'b0;
            r_err   <= 1'b0;
        end else if (w_acc) begin
            r_pos   <= n_pos;
            r_year  <= n_year;
            r_month <= n_month;
            r_day   <= n_day;
            r_hour  <= n_hour;
            r_min   <= n_min;
            r_sec   <= n_sec;
            r_ms    <= n_ms;
            r_fds   <= n_fds;
            r_frac  <= n_frac;
            r_err   <= n_err;
        end
    end

endmodule

[sv/itp_queue.sv]
`timescale 1ns / 1ps

module itp_queue #(
    parameter int P_DEPTH = itp_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  itp_pkg::t_rec     i_rec,
    input  logic              i_pop,
    output itp_pkg::t_rec     o_rec,
    output logic              o_full,
    output logic              o_empty
);

    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    itp_pkg::t_rec r_mem [P_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(P_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rec   = r_mem[r_rd];

    // Store the pushed record
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_rec;
    end

    // Move pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == AW'(P_DEPTH - 1)) ? '0 : AW'(r_wr + 1'b1);
            if (i_pop)  r_rd <= (r_rd == AW'(P_DEPTH - 1)) ? '0 : AW'(r_rd + 1'b1);
            if (i_push && !i_pop)      r_cnt <= CW'(r_cnt + 1'b1);
            else if (i_pop && !i_push) r_cnt <= CW'(r_cnt - 1'b1);
        end
    end

endmodule

[sv/itp_back.sv]
`timescale 1ns / 1ps

module itp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  itp_pkg::t_rec       i_rec,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_valid_res,
    output logic signed [48:0]  o_epoch_millis
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DIV  = 7'b0000010,
        ST_YOE  = 7'b0000100,
        ST_DOE  = 7'b0001000,
        ST_DAYS = 7'b0010000,
        ST_MINS = 7'b0100000,
        ST_MSEC = 7'b1000000
    } t_back_state;

    t_back_state           r_state, n_state;
    logic                  r_out_valid;
    itp_pkg::t_rec         r_rec;
    logic signed [5:0]     r_era;
    logic [8:0]            r_yoe;
    logic signed [22:0]    r_era_days;
    logic [17:0]           r_doe;
    logic signed [22:0]    r_days;
    logic signed [32:0]    r_mins;
    logic                  r_res;
    logic signed [48:0]    r_ms;

    logic signed [14:0]    w_yadj;
    logic                  w_neg;
    logic [26:0]           w_prod;
    logic [4:0]            w_q;
    logic [13:0]           w_yoe_full;
    logic [1:0]            w_c100;
    logic [17:0]           w_doe;
    logic signed [32:0]    w_mins;
    logic signed [48:0]    w_ms;

    assign o_pop          = (r_state == ST_IDLE) && !i_empty;
    assign o_valid        = r_out_valid;
    assign o_valid_res    = r_res;
    assign o_epoch_millis = r_ms;

    // Year counted from March, and its era by reciprocal multiply
    assign w_yadj = $signed({1'b0, r_rec.year}) - $signed({14'd0, (r_rec.month <= 4'd2)});
    assign w_neg  = w_yadj[14];
    assign w_prod = 27'(w_yadj[13:0]) * 27'(itp_pkg::DIV400_RECIP);
    assign w_q    = w_prod[itp_pkg::DIV400_SHIFT +: 5];

    // Year of the era and day of the era
    assign w_yoe_full = 14'(w_yadj[13:0] - 14'(r_era[4:0]) * 14'd400);
    assign w_c100 = (r_yoe >= 9'd300) ? 2'd3 :
                    (r_yoe >= 9'd200) ? 2'd2 :
                    (r_yoe >= 9'd100) ? 2'd1 : 2'd0;
    assign w_doe  = 18'(r_yoe) * 18'd365 + 18'(r_yoe[8:2]) - 18'(w_c100) +
                    18'(itp_pkg::month_offset(r_rec.month)) + 18'(r_rec.day) - 18'd1;

    // Minutes and milliseconds since the epoch
    assign w_mins = $signed({{10{r_days[22]}}, r_days}) * 33'sd1440 +
                    $signed({28'd0, r_rec.hour}) * 33'sd60 +
                    $signed({27'd0, r_rec.minute});
    assign w_ms   = $signed({{16{r_mins[32]}}, r_mins}) * 49'sd60000 +
                    $signed({43'd0, r_rec.sec}) * 49'sd1000 +
                    $signed({39'd0, r_rec.millis});

    // Step through the date arithmetic, one stage a cycle, holding in the last stage while the result is not taken
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (!i_empty) n_state = ST_DIV;
            ST_DIV:  n_state = ST_YOE;
            ST_YOE:  n_state = ST_DOE;
            ST_DOE:  n_state = ST_DAYS;
            ST_DAYS: n_state = ST_MINS;
            ST_MINS: n_state = ST_MSEC;
            ST_MSEC: if (!r_out_valid) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Hold state and the result transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_ready)
                r_out_valid <= 1'b0;
            else if (r_state == ST_MSEC && !r_out_valid)
                r_out_valid <= 1'b1;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) r_rec <= i_rec;
        if (r_state == ST_DIV) r_era <= w_neg ? -6'sd1 : $signed({1'b0, w_q});
        if (r_state == ST_YOE) begin
            r_yoe      <= w_neg ? 9'd399 : w_yoe_full[8:0];
            r_era_days <= $signed({{17{r_era[5]}}, r_era}) * itp_pkg::DAYS_PER_ERA;
        end
        if (r_state == ST_DOE)  r_doe  <= w_doe;
        if (r_state == ST_DAYS) r_days <= r_era_days + $signed({5'd0, r_doe}) -
                                          itp_pkg::EPOCH_SHIFT;
        if (r_state == ST_MINS) r_mins <= w_mins;
        if (r_state == ST_MSEC && !r_out_valid) begin
            r_res <= r_rec.ok;
            r_ms  <= r_rec.ok ? w_ms : '0;
        end
    end

endmodule

[sv/iso_timestamp_parser_unit.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_char_code[7:0], i_last_char
// result    out        o_out_valid / i_out_ready  o_valid_res, o_epoch_millis[48:0]
//
// The parser takes one character per cycle. Once the last character of a string is
// taken, the string is queued, popped and run through six date stages to a result.
// Parsed strings wait in a P_QUEUE_DEPTH entry queue; the input stalls only
// when that queue is full. The sequencer takes one string at a time and
// holds in its last stage while the previous result is not taken.
// Reset (synchronous, active low) clears the parser, the queue and the sequencer.

module iso_timestamp_parser_unit #(
    parameter int P_QUEUE_DEPTH = itp_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_char_code,
    input  logic               i_last_char,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_valid_res,
    output logic signed [48:0] o_epoch_millis
);

    logic          w_push, w_pop, w_full, w_empty;
    itp_pkg::t_rec w_push_rec, w_pop_rec;

    itp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_rec       (w_push_rec)
    );

    itp_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_push_rec),
        .i_pop   (w_pop),
        .o_rec   (w_pop_rec),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    itp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_rec          (w_pop_rec),
        .o_pop          (w_pop),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_valid_res    (o_valid_res),
        .o_epoch_millis (o_epoch_millis)
    );

    // An invalid string reports zero milliseconds
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_valid_res |-> o_epoch_millis == '0)
        else $error("invalid result carries nonzero time");

    // A valid result stays within years 0000 to 9999
    a_valid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_valid_res |->
            (o_epoch_millis >= -49'sd62167219200000) &&
            (o_epoch_millis <= 49'sd253402300799999))
        else $error("valid result out of range");

    // The sequencer never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("pop from empty queue");

    // A taken result leaves the output register empty
    a_out_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready |=> !o_out_valid)
        else $error("result repeated after transaction");

endmodule
